// File: rtl/core/ddpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddpd_pkg;

	// number formats
	localparam int VW        = 32;   // loop state width (speeds, errors)
	localparam int FB        = 16;   // fraction bits of speeds and errors
	localparam int PWM_W     = 16;   // PWM scale width
	localparam int CNT_W     = 32;   // counts, targets, sensor correction
	localparam int GAIN_W    = 16;
	localparam int GAIN_FB   = 8;
	localparam int RAMP_W    = 31;
	localparam int DUTY_W    = 16;
	localparam int SPD_OUT_W = 32;

	// internal widths
	localparam int FBK_W  = CNT_W + FB + 1;
	localparam int ACC_W  = ((FBK_W > VW) ? FBK_W : VW) + 2;
	localparam int PROD_W = GAIN_W + 1 + VW;
	localparam int PLIM   = 58;
	localparam int PD_W   = PLIM + 2;
	localparam int PLIM_W = (PROD_W > PD_W) ? PROD_W : PD_W;
	localparam int MIX_W  = PD_W + 5;
	localparam int DRV_SH = GAIN_FB + FB;
	localparam int PWM_MAX = (1 << PWM_W) - 1;
	localparam int SXW    = (VW > SPD_OUT_W) ? VW : SPD_OUT_W;

	// ports
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int S_TDATA_W  = 200;
	localparam int M_TDATA_W  = 96;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PWM     = 3'd0,
		REG_SLOW_DECAY  = 3'd1,
		REG_GAIN_P_X    = 3'd2,
		REG_GAIN_D_X    = 3'd3,
		REG_RAMP_UP_X   = 3'd4,
		REG_RAMP_DOWN_X = 3'd5,
		REG_RAMP_UP_W   = 3'd6,
		REG_RAMP_DOWN_W = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0]       max_pwm;
		logic              slow_decay;
		logic [GAIN_W-1:0] gain_p_x;
		logic [GAIN_W-1:0] gain_d_x;
		logic [RAMP_W-1:0] ramp_up_x;
		logic [RAMP_W-1:0] ramp_down_x;
		logic [RAMP_W-1:0] ramp_up_w;
		logic [RAMP_W-1:0] ramp_down_w;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0]        left_count;
		logic [CNT_W-1:0]        right_count;
		logic signed [CNT_W-1:0] sensor_correction;
		logic                    use_sensor;
		logic signed [CNT_W-1:0] target_speed_x;
		logic signed [CNT_W-1:0] target_speed_w;
		logic [GAIN_W-1:0]       gain_p_w;
		logic [GAIN_W-1:0]       gain_d_w;
		logic                    clear;
	} in_item_t;

	// per-stage load strobes of the pipeline
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
		logic s8;
		logic s9;
		logic res;
	} ld_t;

	typedef struct packed {
		logic signed [VW-1:0] err_x;
		logic signed [VW-1:0] prev_x;
		logic signed [VW-1:0] err_w;
		logic signed [VW-1:0] prev_w;
		logic signed [VW-1:0] speed_x;
		logic [GAIN_W-1:0]    gain_p_w;
		logic [GAIN_W-1:0]    gain_d_w;
	} err_word_t;

	typedef struct packed {
		logic signed [PD_W:0] px;
		logic signed [PD_W:0] pw;
		logic signed [VW-1:0] speed_x;
	} pd_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0]           left_a;
		logic [DUTY_W-1:0]           left_b;
		logic [DUTY_W-1:0]           right_a;
		logic [DUTY_W-1:0]           right_b;
		logic signed [SPD_OUT_W-1:0] cur_speed_x;
	} res_t;

	// saturate to the signed loop state range
	function automatic logic signed [VW-1:0] sat_v(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
		lo = ~hi;
		if (x > hi)
			return hi[VW-1:0];
		else if (x < lo)
			return lo[VW-1:0];
		else
			return x[VW-1:0];
	endfunction

	// limit a PD product to +-2^PLIM
	function automatic logic signed [PD_W-1:0] clamp_prod(input logic signed [PROD_W-1:0] p);
		logic signed [PLIM_W-1:0] x;
		logic signed [PLIM_W-1:0] lim;
		x   = PLIM_W'(p);
		lim = {{(PLIM_W-PLIM-1){1'b0}}, 1'b1, {PLIM{1'b0}}};
		if (x > lim)
			x = lim;
		else if (x < -lim)
			x = -lim;
		return x[PD_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/ddpd_loop.sv
`timescale 1ns / 1ps
`default_nettype none

module ddpd_loop (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ld,
	input  ddpd_pkg::cfg_t        cfg,
	input  ddpd_pkg::in_item_t    item,
	output ddpd_pkg::err_word_t   err_s2
);

	localparam int AW = ddpd_pkg::ACC_W;
	localparam int VW = ddpd_pkg::VW;
	localparam int CW = ddpd_pkg::CNT_W;

	function automatic logic signed [VW-1:0] ramp_step(
		input logic signed [VW-1:0]                     cur,
		input logic signed [CW-1:0]                     tgt,
		input logic [ddpd_pkg::RAMP_W-1:0]              up,
		input logic [ddpd_pkg::RAMP_W-1:0]              down
	);
		logic signed [AW-1:0] c;
		logic signed [AW-1:0] t;
		logic signed [AW-1:0] u;
		logic signed [AW-1:0] d;
		logic signed [AW-1:0] n;
		c = AW'(cur);
		t = AW'(tgt);
		u = AW'({1'b0, up});
		d = AW'({1'b0, down});
		n = c;
		if (c < t) begin
			n = c + u;
			if (n > t)
				n = t;
		end else if (c > t) begin
			n = c - d;
			if (n < t)
				n = t;
		end
		return ddpd_pkg::sat_v(n);
	endfunction

	logic [CW-1:0]        last_left_q;
	logic [CW-1:0]        last_right_q;
	logic signed [VW-1:0] speed_x_q;
	logic signed [VW-1:0] speed_w_q;
	logic signed [VW-1:0] err_x_q;
	logic signed [VW-1:0] err_w_q;

	logic signed [CW-1:0] dl;
	logic signed [CW-1:0] dr;
	logic signed [AW-1:0] fbx;
	logic signed [AW-1:0] fbw;
	logic signed [VW-1:0] spx_n;
	logic signed [VW-1:0] spw_n;
	logic signed [VW-1:0] errx_n;
	logic signed [VW-1:0] errw_n;

	always_comb begin
		dl = item.left_count - last_left_q;
		dr = item.right_count - last_right_q;
		// half the wheel sum and difference, in fixed point
		fbx = (AW'(dl) + AW'(dr)) <<< (ddpd_pkg::FB - 1);
		fbw = (AW'(dr) - AW'(dl)) <<< (ddpd_pkg::FB - 1);
		if (item.use_sensor)
			fbw = fbw - AW'(item.sensor_correction);
		spx_n = ramp_step(speed_x_q, item.target_speed_x, cfg.ramp_up_x, cfg.ramp_down_x);
		spw_n = ramp_step(speed_w_q, item.target_speed_w, cfg.ramp_up_w, cfg.ramp_down_w);
		errx_n = ddpd_pkg::sat_v(AW'(err_x_q) + AW'(spx_n) - fbx);
		errw_n = ddpd_pkg::sat_v(AW'(err_w_q) + AW'(spw_n) - fbw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_left_q  <= '0;
			last_right_q <= '0;
			speed_x_q    <= '0;
			speed_w_q    <= '0;
			err_x_q      <= '0;
			err_w_q      <= '0;
		end else if (ld) begin
			last_left_q  <= item.left_count;
			last_right_q <= item.right_count;
			if (item.clear) begin
				speed_x_q <= '0;
				speed_w_q <= '0;
				err_x_q   <= '0;
				err_w_q   <= '0;
			end else begin
				speed_x_q <= spx_n;
				speed_w_q <= spw_n;
				err_x_q   <= errx_n;
				err_w_q   <= errw_n;
			end
		end
	end

	// the stored error is the previous error of the next word
	always_ff @(posedge clk) begin
		if (ld) begin
			err_s2.gain_p_w <= item.gain_p_w;
			err_s2.gain_d_w <= item.gain_d_w;
			if (item.clear) begin
				err_s2.err_x   <= '0;
				err_s2.prev_x  <= '0;
				err_s2.err_w   <= '0;
				err_s2.prev_w  <= '0;
				err_s2.speed_x <= '0;
			end else begin
				err_s2.err_x   <= errx_n;
				err_s2.prev_x  <= err_x_q;
				err_s2.err_w   <= errw_n;
				err_s2.prev_w  <= err_w_q;
				err_s2.speed_x <= spx_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/ddpd_pd.sv
`timescale 1ns / 1ps
`default_nettype none

module ddpd_pd (
	input  logic                  clk,
	input  ddpd_pkg::ld_t         ld,
	input  ddpd_pkg::cfg_t        cfg,
	input  ddpd_pkg::err_word_t   err_s2,
	output ddpd_pkg::pd_word_t    pd_s5
);

	localparam int AW = ddpd_pkg::ACC_W;
	localparam int VW = ddpd_pkg::VW;
	localparam int GW = ddpd_pkg::GAIN_W;
	localparam int PW = ddpd_pkg::PD_W;

	typedef struct packed {
		logic signed [VW-1:0] err_x;
		logic signed [VW-1:0] diff_x;
		logic signed [VW-1:0] err_w;
		logic signed [VW-1:0] diff_w;
		logic [GW-1:0]        gain_p_w;
		logic [GW-1:0]        gain_d_w;
		logic signed [VW-1:0] speed_x;
	} diff_word_t;

	typedef struct packed {
		logic signed [PW-1:0] a_x;
		logic signed [PW-1:0] b_x;
		logic signed [PW-1:0] a_w;
		logic signed [PW-1:0] b_w;
		logic signed [VW-1:0] speed_x;
	} prod_word_t;

	diff_word_t st3_s3;
	prod_word_t st4_s4;

	logic signed [GW:0] kpx;
	logic signed [GW:0] kdx;
	logic signed [GW:0] kpw;
	logic signed [GW:0] kdw;
	logic signed [ddpd_pkg::PROD_W-1:0] ax;
	logic signed [ddpd_pkg::PROD_W-1:0] bx;
	logic signed [ddpd_pkg::PROD_W-1:0] aw;
	logic signed [ddpd_pkg::PROD_W-1:0] bw;

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			st3_s3.err_x    <= err_s2.err_x;
			st3_s3.diff_x   <= ddpd_pkg::sat_v(AW'(err_s2.err_x) - AW'(err_s2.prev_x));
			st3_s3.err_w    <= err_s2.err_w;
			st3_s3.diff_w   <= ddpd_pkg::sat_v(AW'(err_s2.err_w) - AW'(err_s2.prev_w));
			st3_s3.gain_p_w <= err_s2.gain_p_w;
			st3_s3.gain_d_w <= err_s2.gain_d_w;
			st3_s3.speed_x  <= err_s2.speed_x;
		end
	end

	// four parallel gain multipliers
	always_comb begin
		kpx = {1'b0, cfg.gain_p_x};
		kdx = {1'b0, cfg.gain_d_x};
		kpw = {1'b0, st3_s3.gain_p_w};
		kdw = {1'b0, st3_s3.gain_d_w};
		ax  = kpx * st3_s3.err_x;
		bx  = kdx * st3_s3.diff_x;
		aw  = kpw * st3_s3.err_w;
		bw  = kdw * st3_s3.diff_w;
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			st4_s4.a_x     <= ddpd_pkg::clamp_prod(ax);
			st4_s4.b_x     <= ddpd_pkg::clamp_prod(bx);
			st4_s4.a_w     <= ddpd_pkg::clamp_prod(aw);
			st4_s4.b_w     <= ddpd_pkg::clamp_prod(bw);
			st4_s4.speed_x <= st3_s3.speed_x;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			pd_s5.px      <= (PW+1)'(st4_s4.a_x) + (PW+1)'(st4_s4.b_x);
			pd_s5.pw      <= (PW+1)'(st4_s4.a_w) + (PW+1)'(st4_s4.b_w);
			pd_s5.speed_x <= st4_s4.speed_x;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/ddpd_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module ddpd_mix (
	input  logic                clk,
	input  ddpd_pkg::ld_t       ld,
	input  ddpd_pkg::cfg_t      cfg,
	input  ddpd_pkg::pd_word_t  pd_s5,
	output ddpd_pkg::res_t      res_q
);

	localparam int MW  = ddpd_pkg::MIX_W;
	localparam int VW  = ddpd_pkg::VW;
	localparam int PWW = ddpd_pkg::PWM_W;
	localparam int DW  = ddpd_pkg::DUTY_W;
	localparam int XW  = ddpd_pkg::SXW;
	localparam int OW  = ddpd_pkg::SPD_OUT_W;

	typedef struct packed {
		logic signed [MW-1:0] lt;
		logic signed [MW-1:0] rt;
		logic signed [VW-1:0] speed_x;
	} drive_word_t;

	typedef struct packed {
		logic                 neg_l;
		logic [PWW-1:0]       mag_l;
		logic                 neg_r;
		logic [PWW-1:0]       mag_r;
		logic signed [VW-1:0] speed_x;
	} mag_word_t;

	drive_word_t st6_s6;
	drive_word_t st7_s7;
	drive_word_t st8_s8;
	mag_word_t   st9_s9;

	logic [PWW-1:0]       mx;
	logic signed [MW-1:0] maxf;
	logic signed [MW-1:0] rt7;
	logic signed [MW-1:0] lt8;
	logic signed [MW-1:0] tot_l;
	logic signed [MW-1:0] tot_r;
	logic signed [MW-1:0] abs_l;
	logic signed [MW-1:0] abs_r;
	logic signed [XW-1:0] spd_w;
	logic signed [XW-1:0] spd_hi;
	logic signed [XW-1:0] spd_lo;
	logic signed [OW-1:0] spd_out;

	always_comb begin
		mx = (cfg.max_pwm > 16'(ddpd_pkg::PWM_MAX)) ? PWW'(ddpd_pkg::PWM_MAX)
		                                            : PWW'(cfg.max_pwm);
		maxf = MW'(mx) <<< ddpd_pkg::DRV_SH;
	end

	always_ff @(posedge clk) begin
		if (ld.s6) begin
			st6_s6.lt      <= MW'(pd_s5.px) - MW'(pd_s5.pw);
			st6_s6.rt      <= MW'(pd_s5.px) + MW'(pd_s5.pw);
			st6_s6.speed_x <= pd_s5.speed_x;
		end
	end

	// shift the left excess over to the right drive
	always_comb begin
		rt7 = st6_s6.rt;
		if (st6_s6.lt > maxf)
			rt7 = st6_s6.rt - (st6_s6.lt - maxf);
		else if (st6_s6.lt < -maxf)
			rt7 = st6_s6.rt + (-maxf - st6_s6.lt);
	end

	always_ff @(posedge clk) begin
		if (ld.s7) begin
			st7_s7.lt      <= st6_s6.lt;
			st7_s7.rt      <= rt7;
			st7_s7.speed_x <= st6_s6.speed_x;
		end
	end

	// then the right excess back to the left, using the updated right drive
	always_comb begin
		lt8 = st7_s7.lt;
		if (st7_s7.rt > maxf)
			lt8 = st7_s7.lt - (st7_s7.rt - maxf);
		else if (st7_s7.rt < -maxf)
			lt8 = st7_s7.lt + (-maxf - st7_s7.rt);
	end

	always_ff @(posedge clk) begin
		if (ld.s8) begin
			st8_s8.lt      <= lt8;
			st8_s8.rt      <= st7_s7.rt;
			st8_s8.speed_x <= st7_s7.speed_x;
		end
	end

	// clamp to full scale and truncate toward zero
	always_comb begin
		tot_l = st8_s8.lt;
		if (tot_l > maxf)
			tot_l = maxf;
		else if (tot_l < -maxf)
			tot_l = -maxf;
		tot_r = st8_s8.rt;
		if (tot_r > maxf)
			tot_r = maxf;
		else if (tot_r < -maxf)
			tot_r = -maxf;
		abs_l = (tot_l < 0) ? -tot_l : tot_l;
		abs_r = (tot_r < 0) ? -tot_r : tot_r;
	end

	always_ff @(posedge clk) begin
		if (ld.s9) begin
			st9_s9.neg_l   <= tot_l < 0;
			st9_s9.mag_l   <= PWW'(abs_l >>> ddpd_pkg::DRV_SH);
			st9_s9.neg_r   <= tot_r < 0;
			st9_s9.mag_r   <= PWW'(abs_r >>> ddpd_pkg::DRV_SH);
			st9_s9.speed_x <= st8_s8.speed_x;
		end
	end

	always_comb begin
		spd_w  = XW'(st9_s9.speed_x);
		spd_hi = XW'({1'b0, {(OW-1){1'b1}}});
		spd_lo = ~spd_hi;
		if (spd_w > spd_hi)
			spd_out = spd_hi[OW-1:0];
		else if (spd_w < spd_lo)
			spd_out = spd_lo[OW-1:0];
		else
			spd_out = spd_w[OW-1:0];
	end

	// A/B mapping; a zero drive in slow decay brakes with both sides at full scale
	always_ff @(posedge clk) begin
		if (ld.res) begin
			res_q.cur_speed_x <= spd_out;
			if (cfg.slow_decay) begin
				res_q.left_a  <= st9_s9.neg_l ? DW'(mx - st9_s9.mag_l) : DW'(mx);
				res_q.left_b  <= st9_s9.neg_l ? DW'(mx) : DW'(mx - st9_s9.mag_l);
				res_q.right_a <= st9_s9.neg_r ? DW'(mx - st9_s9.mag_r) : DW'(mx);
				res_q.right_b <= st9_s9.neg_r ? DW'(mx) : DW'(mx - st9_s9.mag_r);
			end else begin
				res_q.left_a  <= st9_s9.neg_l ? '0 : DW'(st9_s9.mag_l);
				res_q.left_b  <= st9_s9.neg_l ? DW'(st9_s9.mag_l) : '0;
				res_q.right_a <= st9_s9.neg_r ? '0 : DW'(st9_s9.mag_r);
				res_q.right_b <= st9_s9.neg_r ? DW'(st9_s9.mag_r) : '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/diff_drive_pd_speed_loop.sv
`timescale 1ns / 1ps
`default_nettype none

// Differential-drive PD speed loop: one control tick per word.
// Input stream (s_t*): one word per tick with the raw encoder counts, the
//   target speeds, the rotational gains, the sensor correction and a clear flag.
// Output stream (m_t*): one word per tick with the left/right A/B PWM duties
//   and the ramped forward speed.
// Configuration (cfg_*): write-only registers, written on any edge with
//   cfg_we high; change them only while no word is in flight.
// Throughput: one word per cycle while m_tready is high. The tick-to-tick
//   dependency (encoder deltas, speed ramps and error accumulation) closes
//   in the single stage behind the input register; PD products, drive
//   mixing and PWM mapping run in the following register stages.
// Pipeline: ten register stages; a word passes from the input register
//   through the work stages to the result register that drives m_t*.
// Reset: config registers take their defaults (full scale 1000, slow decay,
//   all gains and ramp steps zero), loop state clears, the pipeline empties.
// Stall: with m_tready low each stage holds its word and bubbles close up,
//   so s_tready stays high until every stage is full.
module diff_drive_pd_speed_loop (
	input  logic                                clk,
	input  logic                                arst_n,

	// left_count[31:0], right_count[63:32], sensor_correction[95:64],
	// use_sensor[96], target_speed_x[128:97], target_speed_w[160:129],
	// gain_p_w[176:161], gain_d_w[192:177], clear[193], zero fill above
	input  logic [ddpd_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,

	// left_a[15:0], left_b[31:16], right_a[47:32], right_b[63:48],
	// cur_speed_x[95:64]
	output logic [ddpd_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,

	input  logic                                cfg_we,
	input  logic [ddpd_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  logic [ddpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int STG_N = 10;   // input register, eight work stages, result

	ddpd_pkg::cfg_t      cfg_q;
	ddpd_pkg::in_item_t  item_s1;
	ddpd_pkg::err_word_t err_s2;
	ddpd_pkg::pd_word_t  pd_s5;
	ddpd_pkg::res_t      res_q;
	ddpd_pkg::ld_t       ld_bus;

	logic [STG_N-1:0] vld_q;
	logic [STG_N:0]   rdy;
	logic [STG_N-1:0] ld;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{max_pwm: 16'd1000, slow_decay: 1'b1, default: '0};
		end else if (cfg_we) begin
			unique case (ddpd_pkg::cfg_reg_t'(cfg_addr))
				ddpd_pkg::REG_MAX_PWM:     cfg_q.max_pwm     <= cfg_data[15:0];
				ddpd_pkg::REG_SLOW_DECAY:  cfg_q.slow_decay  <= cfg_data[0];
				ddpd_pkg::REG_GAIN_P_X:    cfg_q.gain_p_x    <= cfg_data[ddpd_pkg::GAIN_W-1:0];
				ddpd_pkg::REG_GAIN_D_X:    cfg_q.gain_d_x    <= cfg_data[ddpd_pkg::GAIN_W-1:0];
				ddpd_pkg::REG_RAMP_UP_X:   cfg_q.ramp_up_x   <= cfg_data[ddpd_pkg::RAMP_W-1:0];
				ddpd_pkg::REG_RAMP_DOWN_X: cfg_q.ramp_down_x <= cfg_data[ddpd_pkg::RAMP_W-1:0];
				ddpd_pkg::REG_RAMP_UP_W:   cfg_q.ramp_up_w   <= cfg_data[ddpd_pkg::RAMP_W-1:0];
				ddpd_pkg::REG_RAMP_DOWN_W: cfg_q.ramp_down_w <= cfg_data[ddpd_pkg::RAMP_W-1:0];
			endcase
		end
	end

	// Per-stage ready: a stage takes a word when it is empty or its word moves on.
	always_comb begin
		rdy[STG_N] = m_tready;
		for (int k = STG_N - 1; k >= 0; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
		ld[0] = rdy[0] && s_tvalid;
		for (int k = 1; k < STG_N; k++)
			ld[k] = rdy[k] && vld_q[k-1];
	end

	// advance valid bits where a stage is ready, hold them where it is not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= (vld_q & ~rdy[STG_N-1:0]) |
			         ({vld_q[STG_N-2:0], s_tvalid} & rdy[STG_N-1:0]);
	end

	assign ld_bus = '{s2: ld[1], s3: ld[2], s4: ld[3], s5: ld[4], s6: ld[5],
	                  s7: ld[6], s8: ld[7], s9: ld[8], res: ld[9]};

	// input register: unpack the word
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			item_s1.left_count        <= s_tdata[31:0];
			item_s1.right_count       <= s_tdata[63:32];
			item_s1.sensor_correction <= s_tdata[95:64];
			item_s1.use_sensor        <= s_tdata[96];
			item_s1.target_speed_x    <= s_tdata[128:97];
			item_s1.target_speed_w    <= s_tdata[160:129];
			item_s1.gain_p_w          <= s_tdata[176:161];
			item_s1.gain_d_w          <= s_tdata[192:177];
			item_s1.clear             <= s_tdata[193];
		end
	end

	// state loop: deltas, ramps, error accumulation
	ddpd_loop u_loop (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (ld_bus.s2),
		.cfg    (cfg_q),
		.item   (item_s1),
		.err_s2 (err_s2)
	);

	// error difference, gain products, PD sums
	ddpd_pd u_pd (
		.clk    (clk),
		.ld     (ld_bus),
		.cfg    (cfg_q),
		.err_s2 (err_s2),
		.pd_s5  (pd_s5)
	);

	// mixing, saturation compensation, clamp and A/B mapping
	ddpd_mix u_mix (
		.clk   (clk),
		.ld    (ld_bus),
		.cfg   (cfg_q),
		.pd_s5 (pd_s5),
		.res_q (res_q)
	);

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[STG_N-1];
	assign m_tdata  = {res_q.cur_speed_x, res_q.right_b, res_q.right_a,
	                   res_q.left_b, res_q.left_a};

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import ddpd_pkg::*;

	// Give up after this many cycles in which no word moves on either side.
	localparam int STALL_LIMIT = 2000;
	// Receiver hold-off that fills the pipeline and stalls the input side.
	localparam int HOLD_CYCLES = 150;
	// Idle cycles after the last result before settings change or the run ends.
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 200;
	localparam int CORNER_TICKS = 10;

	// Expected drive words plus a private copy of the loop state and settings.
	class speed_loop_sb;
		cfg_t        regs;
		logic [31:0] last_l, last_r;
		longint      spd_x, spd_w, acc_x, acc_w, prev_x, prev_w;
		res_t        exp_duty_q[$];
		int          errors;

		function new();
			regs = '0;
			regs.max_pwm = 16'd1000;
			regs.slow_decay = 1'b1;
			last_l = '0;
			last_r = '0;
			spd_x = 0;
			spd_w = 0;
			acc_x = 0;
			acc_w = 0;
			prev_x = 0;
			prev_w = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
			case (r)
				REG_MAX_PWM:     regs.max_pwm = v[15:0];
				REG_SLOW_DECAY:  regs.slow_decay = v[0];
				REG_GAIN_P_X:    regs.gain_p_x = v[GAIN_W-1:0];
				REG_GAIN_D_X:    regs.gain_d_x = v[GAIN_W-1:0];
				REG_RAMP_UP_X:   regs.ramp_up_x = v[RAMP_W-1:0];
				REG_RAMP_DOWN_X: regs.ramp_down_x = v[RAMP_W-1:0];
				REG_RAMP_UP_W:   regs.ramp_up_w = v[RAMP_W-1:0];
				REG_RAMP_DOWN_W: regs.ramp_down_w = v[RAMP_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint x, longint lo, longint hi);
			return (x < lo) ? lo : ((x > hi) ? hi : x);
		endfunction

		function longint sat_val(longint x);
			longint lim;
			lim = longint'(1) << (VW - 1);
			return clamp(x, -lim, lim - 1);
		endfunction

		function longint ramp_step(longint cur, longint tgt, longint up, longint down);
			if (cur < tgt) begin
				cur += up;
				if (cur > tgt)
					cur = tgt;
			end else if (cur > tgt) begin
				cur -= down;
				if (cur < tgt)
					cur = tgt;
			end
			return sat_val(cur);
		endfunction

		function longint pd_term(longint e, longint p, longint kp, longint kd);
			longint lim;
			longint d;
			lim = longint'(1) << PLIM;
			d = sat_val(e - p);
			return clamp(kp * e, -lim, lim) + clamp(kd * d, -lim, lim);
		endfunction

		// Clamp to full scale, then drop the fraction toward zero.
		function longint to_duty(longint tot, longint maxf);
			tot = clamp(tot, -maxf, maxf);
			return (tot < 0) ? -((-tot) >> DRV_SH) : (tot >> DRV_SH);
		endfunction

		function void map_pair(longint pwm, longint mx, output logic [DUTY_W-1:0] a,
				output logic [DUTY_W-1:0] b);
			longint mag;
			mag = (pwm < 0) ? -pwm : pwm;
			if (regs.slow_decay) begin
				a = (pwm >= 0) ? DUTY_W'(mx) : DUTY_W'(mx - mag);
				b = (pwm >= 0) ? DUTY_W'(mx - mag) : DUTY_W'(mx);
			end else begin
				a = (pwm >= 0) ? DUTY_W'(mag) : '0;
				b = (pwm >= 0) ? '0 : DUTY_W'(mag);
			end
		endfunction

		// Advance the loop by one accepted tick and queue the drive it produces.
		function void note_tick(in_item_t it);
			longint      mx, maxf, dl, dr, fbx, fbw, px, pw, lt, rt;
			logic [31:0] dl32, dr32;
			res_t        r;
			mx = longint'(regs.max_pwm);
			if (mx > PWM_MAX)
				mx = PWM_MAX;
			maxf = mx * (longint'(1) << DRV_SH);
			dl32 = it.left_count - last_l;
			dr32 = it.right_count - last_r;
			dl = $signed(dl32);
			dr = $signed(dr32);
			last_l = it.left_count;
			last_r = it.right_count;
			if (it.clear) begin
				spd_x = 0;
				spd_w = 0;
				acc_x = 0;
				acc_w = 0;
				prev_x = 0;
				prev_w = 0;
				lt = 0;
				rt = 0;
			end else begin
				spd_x = ramp_step(spd_x, it.target_speed_x, regs.ramp_up_x, regs.ramp_down_x);
				spd_w = ramp_step(spd_w, it.target_speed_w, regs.ramp_up_w, regs.ramp_down_w);
				fbx = (dl + dr) * (longint'(1) << (FB - 1));
				fbw = (dr - dl) * (longint'(1) << (FB - 1));
				if (it.use_sensor)
					fbw -= it.sensor_correction;
				acc_x = sat_val(acc_x + (spd_x - fbx));
				acc_w = sat_val(acc_w + (spd_w - fbw));
				px = pd_term(acc_x, prev_x, regs.gain_p_x, regs.gain_d_x);
				pw = pd_term(acc_w, prev_w, it.gain_p_w, it.gain_d_w);
				prev_x = acc_x;
				prev_w = acc_w;
				lt = px - pw;
				rt = px + pw;
				// push the excess of the left drive onto the right, then back
				if (lt > maxf)
					rt -= lt - maxf;
				else if (lt < -maxf)
					rt += -maxf - lt;
				if (rt > maxf)
					lt -= rt - maxf;
				else if (rt < -maxf)
					lt += -maxf - rt;
			end
			map_pair(to_duty(lt, maxf), mx, r.left_a, r.left_b);
			map_pair(to_duty(rt, maxf), mx, r.right_a, r.right_b);
			r.cur_speed_x = 32'(clamp(spd_x, -(longint'(1) << 31), (longint'(1) << 31) - 1));
			exp_duty_q.push_back(r);
		endfunction

		function void cmp_field(string name, longint exp_v, longint act_v);
			if (exp_v != act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_duties(res_t got);
			res_t want;
			if (exp_duty_q.size() == 0) begin
				$error("unexpected drive word: left_a %0d left_b %0d right_a %0d right_b %0d",
					got.left_a, got.left_b, got.right_a, got.right_b);
				errors++;
				return;
			end
			want = exp_duty_q.pop_front();
			cmp_field("left_a", want.left_a, got.left_a);
			cmp_field("left_b", want.left_b, got.left_b);
			cmp_field("right_a", want.right_a, got.right_a);
			cmp_field("right_b", want.right_b, got.right_b);
			cmp_field("cur_speed_x", want.cur_speed_x, got.cur_speed_x);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Running encoder positions for well-formed ticks.
	logic [31:0] enc_l = '0;
	logic [31:0] enc_r = '0;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit          hold_req = 1'b0;

	speed_loop_sb sb;

	always #2 clk = ~clk;

	diff_drive_pd_speed_loop dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	function automatic in_item_t tick_of(logic [31:0] lc, logic [31:0] rc, logic [31:0] corr,
			logic us, logic [31:0] tx, logic [31:0] tw, logic [15:0] kp, logic [15:0] kd,
			logic clr);
		in_item_t it;
		it.left_count = lc;
		it.right_count = rc;
		it.sensor_correction = corr;
		it.use_sensor = us;
		it.target_speed_x = tx;
		it.target_speed_w = tw;
		it.gain_p_w = kp;
		it.gain_d_w = kd;
		it.clear = clr;
		return it;
	endfunction

	// Field extremes, count wrap, sensor on/off and clear.
	function automatic in_item_t corner_tick(int k);
		case (k)
			0: return tick_of(0, 0, 0, 0, 0, 0, 0, 0, 0);
			// clear while the counts sit at opposite extremes
			1: return tick_of(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 0, 1);
			// both deltas wrap, targets at opposite extremes, full gains
			2: return tick_of(32'h80000000, 32'h7fffffff, 0, 0, 32'h7fffffff, 32'h80000000,
				16'hffff, 16'hffff, 0);
			3: return tick_of(0, 0, 32'h7fffffff, 1, 32'h80000000, 32'h7fffffff, 16'hffff, 0, 0);
			4: return tick_of(0, 0, 32'h80000000, 1, 0, 0, 0, 16'hffff, 0);
			// correction present but not selected
			5: return tick_of('1, '1, '1, 0, '1, '1, '1, '1, 0);
			6: return tick_of('1, '1, '1, 1, '1, '1, '1, '1, 1);
			7: return tick_of(100, 300, 0, 0, 32'h000a0000, 32'h00020000, 16'h0100, 16'h0080, 0);
			8: return tick_of(200, 200, 0, 0, 0, 0, 0, 0, 0);
			default: return tick_of(200, 0, 32'h00050000, 1, 32'hfff00000, 32'h00100000,
				16'h0100, 16'h0080, 0);
		endcase
	endfunction

	// Plausible tick: mostly small wheel deltas, targets of the same scale, mostly moderate gains.
	function automatic in_item_t loop_tick();
		int       dl, dr;
		in_item_t it;
		dl = int'($urandom_range(0, 600)) - 300;
		dr = int'($urandom_range(0, 600)) - 300;
		if ($urandom_range(0, 31) == 0)
			dl = int'($urandom);
		enc_l += dl;
		enc_r += dr;
		it.left_count = enc_l;
		it.right_count = enc_r;
		it.sensor_correction = (int'($urandom_range(0, 20000)) - 10000) * 16;
		it.use_sensor = $urandom_range(0, 1);
		it.target_speed_x = ((int'($urandom_range(0, 400)) - 200) <<< 16) +
			int'($urandom_range(0, 65535));
		it.target_speed_w = ((int'($urandom_range(0, 200)) - 100) <<< 16) +
			int'($urandom_range(0, 65535));
		it.gain_p_w = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
		it.gain_d_w = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
		it.clear = ($urandom_range(0, 63) == 0);
		return it;
	endfunction

	// Any bit pattern at all.
	function automatic in_item_t noise_tick();
		return tick_of($urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom, $urandom,
			16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
	endfunction

	function automatic cfg_t phase_settings(int p);
		cfg_t c;
		case (p)
			0: c = '{16'd1000, 1'b1, 16'd256, 16'd64, 31'd8192, 31'd16384, 31'd4096, 31'd2048};
			// everything at its top end but slow decay, which is off
			1: c = '{16'hffff, 1'b0, 16'hffff, 16'hffff, '1, '1, '1, '1};
			// zero full scale
			2: c = '{16'd0, 1'b1, 16'd512, 16'd0, 31'h10000, 31'h10000, 31'h10000, 31'h10000};
			3: c = '{16'd255, 1'b0, 16'd128, 16'd256, 31'd3000, 31'd60000, 31'd1, 31'd0};
			// ramps and forward gains all zero
			4: c = '{16'd1000, 1'b0, 16'd0, 16'd0, 31'd0, 31'd0, 31'd0, 31'd0};
			5: c = '{16'($urandom), 1'($urandom), 16'($urandom_range(0, 2048)),
				16'($urandom_range(0, 2048)), 31'($urandom_range(0, 1 << 18)),
				31'($urandom_range(0, 1 << 18)), 31'($urandom_range(0, 1 << 18)),
				31'($urandom_range(0, 1 << 18))};
			6: c = '{16'($urandom), 1'($urandom), 16'($urandom), 16'($urandom), 31'($urandom),
				31'($urandom), 31'($urandom), 31'($urandom)};
			default: c = '{16'd4095, 1'b1, 16'd1024, 16'd512, 31'($urandom_range(0, 1 << 20)),
				31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)),
				31'($urandom_range(0, 1 << 20))};
		endcase
		return c;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] reg_value(cfg_t c, cfg_reg_t r);
		case (r)
			REG_MAX_PWM:     return CFG_DATA_W'(c.max_pwm);
			REG_SLOW_DECAY:  return CFG_DATA_W'(c.slow_decay);
			REG_GAIN_P_X:    return CFG_DATA_W'(c.gain_p_x);
			REG_GAIN_D_X:    return CFG_DATA_W'(c.gain_d_x);
			REG_RAMP_UP_X:   return CFG_DATA_W'(c.ramp_up_x);
			REG_RAMP_DOWN_X: return CFG_DATA_W'(c.ramp_down_x);
			REG_RAMP_UP_W:   return CFG_DATA_W'(c.ramp_up_w);
			default:         return CFG_DATA_W'(c.ramp_down_w);
		endcase
	endfunction

	// Write every register in turn; hold the enable high across the run of writes.
	task automatic apply_settings(cfg_t c);
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we <= 1'b1;
			cfg_addr <= r;
			cfg_data <= reg_value(c, r);
			@(posedge clk);
			sb.set_reg(r, reg_value(c, r));
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
	endtask

	// Offer one word and hold it until the block takes it.
	task automatic send_tick(in_item_t it);
		s_tdata <= S_TDATA_W'({it.clear, it.gain_d_w, it.gain_p_w, it.target_speed_w,
			it.target_speed_x, it.use_sensor, it.sensor_correction, it.right_count,
			it.left_count});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_tick(it);
	endtask

	// Drop valid, wait for every expected word, then let the pipeline go quiet.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.exp_duty_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stim
		int gap;
		int burst;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner ticks under the reset settings, then again with everything maxed but slow decay
		for (int k = 0; k < CORNER_TICKS; k++)
			send_tick(corner_tick(k));
		settle();
		apply_settings(phase_settings(1));
		for (int k = 0; k < CORNER_TICKS; k++)
			send_tick(corner_tick(k));
		settle();

		// Random phases. The first three run back to back with no sender gaps;
		// the third asks for the long receiver hold-off to back the block up.
		for (int p = 0; p < PHASES; p++) begin
			apply_settings(phase_settings(p));
			burst = 0;
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (p == 2 && n == 20)
					hold_req = 1'b1;
				if (p > 2 && burst == 0) begin
					burst = $urandom_range(1, 24);
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					if (gap > 0) begin
						s_tvalid <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				if (burst > 0)
					burst--;
				send_tick(($urandom_range(0, 6) == 0) ? noise_tick() : loop_tick());
			end
			settle();
		end

		if (sb.errors == 0)
			$display("PASS diff_drive_pd_speed_loop");
		else
			$display("FAIL diff_drive_pd_speed_loop");
		$finish;
	end

	// Receiver: check each accepted word, then pick the next ready level from
	// a mode that is drawn anew at random now and again, or hold off on request.
	initial begin : sink
		res_t got;
		int   mode;
		int   hold_left;
		int   cyc;
		mode = 0;
		hold_left = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.left_a = m_tdata[15:0];
				got.left_b = m_tdata[31:16];
				got.right_a = m_tdata[47:32];
				got.right_b = m_tdata[63:48];
				got.cur_speed_x = m_tdata[95:64];
				sb.check_duties(got);
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= (cyc % 4 != 3);
					default: m_tready <= (cyc % 3 == 0);
				endcase
			end
			cyc++;
			if (cyc % 256 == 0)
				mode = $urandom_range(0, 3);
		end
	end

	// Watchdog: count cycles in which no word moves on either side.
	initial begin : watchdog
		int stuck;
		stuck = 0;
		@(posedge arst_n);
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck = 0;
			else
				stuck++;
		end
		$display("FAIL diff_drive_pd_speed_loop");
		$finish;
	end

endmodule
